@@ src/cpwm_pkg.sv @@
`default_nettype none
package cpwm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PHASE_W   = 16;
  localparam int AMP_W     = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = SAMPLE_W + 2;
  localparam int DIST_W    = CFG_W + 1;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int OP_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd3;

  localparam logic [AMP_W-1:0] AMPLITUDE_RST = 15'd4096;
  localparam logic [CFG_W-1:0] PERIOD_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] STEP_RST      = 16'd1;
  localparam logic [CFG_W-1:0] SCALE_RST     = 16'd256;

  localparam logic [OP_W-1:0] OP_PHASE   = 3'd0;
  localparam logic [OP_W-1:0] OP_CARRIER = 3'd1;
  localparam logic [OP_W-1:0] OP_LEVEL_A = 3'd2;
  localparam logic [OP_W-1:0] OP_LEVEL_B = 3'd3;
  localparam logic [OP_W-1:0] OP_LEVEL_C = 3'd4;
  localparam logic [OP_W-1:0] OP_NEXT    = 3'd5;

  typedef struct packed {
    logic            load;
    logic            diff;
    logic            span;
    logic            mul;
    logic            start;
    logic            store;
    logic            emit;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

@@ src/cpwm_if.sv @@
`default_nettype none
interface cpwm_in_if;
  import cpwm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] voltage_a;
  logic signed [SAMPLE_W-1:0] voltage_b;
  logic signed [SAMPLE_W-1:0] voltage_c;
  modport source(output valid, voltage_a, voltage_b, voltage_c, input ready);
  modport sink(input valid, voltage_a, voltage_b, voltage_c, output ready);
endinterface

interface cpwm_out_if;
  import cpwm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       switch_a;
  logic                       switch_b;
  logic                       switch_c;
  logic signed [SAMPLE_W-1:0] carrier_value;
  modport source(output valid, switch_a, switch_b, switch_c, carrier_value, input ready);
  modport sink(input valid, switch_a, switch_b, switch_c, carrier_value, output ready);
endinterface
`default_nettype wire

@@ src/carrier_pwm_min_max_injection.sv @@
// each accepted item is carried through to its result before the next item is accepted
// work per item: six 32-step divisions in turn on one shared divider
// a new item is taken while the previous result still waits in the output register
// reset: synchronous, active high; restores register defaults and clears the carrier phase
`default_nettype none
module carrier_pwm_min_max_injection
  import cpwm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  cpwm_in_if.sink                   in_ch,
  cpwm_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  cpwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cpwm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .voltage_a    (in_ch.voltage_a),
    .voltage_b    (in_ch.voltage_b),
    .voltage_c    (in_ch.voltage_c),
    .switch_a     (out_ch.switch_a),
    .switch_b     (out_ch.switch_b),
    .switch_c     (out_ch.switch_c),
    .carrier_value(out_ch.carrier_value)
  );

endmodule
`default_nettype wire

@@ src/cpwm_div.sv @@
`default_nettype none
module cpwm_div
  import cpwm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [CFG_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient,
  output logic      [CFG_W-1:0] remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CFG_W:0]       rem;
  logic [DIV_W-1:0]     quo;
  logic [CFG_W:0]       trial;
  logic [CFG_W:0]       trial_sub;
  logic                 fits;

  always_comb begin
    trial     = {rem[CFG_W-1:0], quo[DIV_W-1]};
    fits      = trial >= {1'b0, divisor};
    trial_sub = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? trial_sub : trial;
    end
  end

  assign quotient  = quo;
  assign remainder = rem[CFG_W-1:0];

endmodule
`default_nettype wire

@@ src/cpwm_datapath.sv @@
`default_nettype none
module cpwm_datapath
  import cpwm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cmd_t                       cmd,
  output status_t                         status,
  input  wire logic                       cfg_we,
  input  wire logic       [CFG_IDX_W-1:0] cfg_index,
  input  wire logic       [CFG_W-1:0]     cfg_data,
  input  wire logic signed [SAMPLE_W-1:0] voltage_a,
  input  wire logic signed [SAMPLE_W-1:0] voltage_b,
  input  wire logic signed [SAMPLE_W-1:0] voltage_c,
  output logic                            switch_a,
  output logic                            switch_b,
  output logic                            switch_c,
  output logic signed [SAMPLE_W-1:0]      carrier_value
);

  localparam logic [SAMPLE_W-1:0] LVL_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] LVL_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic [AMP_W-1:0]   amplitude;
  logic [CFG_W-1:0]   period;
  logic [CFG_W-1:0]   step;
  logic [CFG_W-1:0]   scale;
  logic [PHASE_W-1:0] phase;

  logic signed [SAMPLE_W-1:0] va, vb, vc;
  logic signed [DIFF_W-1:0]   diff_a, diff_b, diff_c;
  logic [CFG_W-1:0]           t;
  logic [DIST_W-1:0]          span;
  logic [DIV_W-1:0]           prod;
  logic [SAMPLE_W-1:0]        car;
  logic                       sw_a, sw_b, sw_c;

  logic signed [SAMPLE_W-1:0] mx, mn;
  logic signed [SAMPLE_W:0]   cm_sum;
  logic signed [SAMPLE_W:0]   cm;
  logic signed [DIFF_W-1:0]   diff_sel;
  logic [DIFF_W-1:0]          mag;
  logic [CFG_W:0]             next_sum;
  logic [CFG_W+2:0]           four_t;
  logic signed [CFG_W+2:0]    u_raw, u, d_raw, d_abs;
  logic [DIV_W-1:0]           dividend;
  logic [CFG_W-1:0]           divisor;
  logic [DIV_W-1:0]           quo;
  logic [CFG_W-1:0]           rem;
  logic                       div_done;
  logic [SAMPLE_W-1:0]        lvl;
  logic [SAMPLE_W-1:0]        car_next;
  logic                       lvl_ge;

  cpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  assign status.div_done = div_done;

  always_comb begin
    mx = va;
    mn = va;
    if (vb > mx) mx = vb;
    if (vc > mx) mx = vc;
    if (vb < mn) mn = vb;
    if (vc < mn) mn = vc;
    cm_sum = {mx[SAMPLE_W-1], mx} + {mn[SAMPLE_W-1], mn};
    cm     = cm_sum >>> 1;
  end

  always_comb begin
    unique case (cmd.op)
      OP_LEVEL_A: diff_sel = diff_a;
      OP_LEVEL_B: diff_sel = diff_b;
      default:    diff_sel = diff_c;
    endcase
    mag      = diff_sel[DIFF_W-1] ? DIFF_W'(-diff_sel) : DIFF_W'(diff_sel);
    next_sum = {1'b0, t} + {1'b0, step};
  end

  always_comb begin
    four_t = {1'b0, t, 2'b00};
    u_raw  = $signed(four_t) - $signed({3'b000, period});
    u      = (u_raw < 0) ? u_raw + $signed({1'b0, period, 2'b00}) : u_raw;
    d_raw  = u - $signed({2'b00, period, 1'b0});
    d_abs  = (d_raw < 0) ? -d_raw : d_raw;
  end

  always_comb begin
    unique case (cmd.op)
      OP_PHASE:   dividend = DIV_W'(phase);
      OP_CARRIER: dividend = prod;
      OP_LEVEL_A, OP_LEVEL_B, OP_LEVEL_C: dividend = DIV_W'({mag, 8'h00});
      OP_NEXT:    dividend = DIV_W'(next_sum);
      default:    dividend = '0;
    endcase
    divisor = (cmd.op == OP_LEVEL_A || cmd.op == OP_LEVEL_B || cmd.op == OP_LEVEL_C)
              ? scale : period;
  end

  always_comb begin
    if (scale == '0) begin
      if (diff_sel == '0)              lvl = '0;
      else if (diff_sel[DIFF_W-1])     lvl = LVL_MIN;
      else                             lvl = LVL_MAX;
    end else if (diff_sel[DIFF_W-1]) begin
      if (quo > DIV_W'(2**(SAMPLE_W-1))) lvl = LVL_MIN;
      else                               lvl = '0 - quo[SAMPLE_W-1:0];
    end else begin
      if (quo > DIV_W'(2**(SAMPLE_W-1) - 1)) lvl = LVL_MAX;
      else                                   lvl = quo[SAMPLE_W-1:0];
    end
    lvl_ge = $signed(lvl) >= $signed(car);
    if (period == '0) car_next = '0 - {1'b0, amplitude};
    else              car_next = quo[SAMPLE_W-1:0] - {1'b0, amplitude};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMPLITUDE_RST;
      period    <= PERIOD_RST;
      step      <= STEP_RST;
      scale     <= SCALE_RST;
      phase     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AMPLITUDE: amplitude <= cfg_data[AMP_W-1:0];
          CFG_PERIOD:    period    <= cfg_data;
          CFG_STEP:      step      <= cfg_data;
          CFG_SCALE:     scale     <= cfg_data;
        endcase
      end
      if (cmd.store && cmd.op == OP_NEXT) begin
        phase <= (period == '0) ? '0 : PHASE_W'(rem);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va <= voltage_a;
      vb <= voltage_b;
      vc <= voltage_c;
    end
    if (cmd.diff) begin
      diff_a <= {{2{va[SAMPLE_W-1]}}, va} - {cm[SAMPLE_W], cm};
      diff_b <= {{2{vb[SAMPLE_W-1]}}, vb} - {cm[SAMPLE_W], cm};
      diff_c <= {{2{vc[SAMPLE_W-1]}}, vc} - {cm[SAMPLE_W], cm};
    end
    if (cmd.span) begin
      span <= DIST_W'(d_abs);
    end
    if (cmd.mul) begin
      prod <= {{(DIV_W-AMP_W){1'b0}}, amplitude} * {{(DIV_W-DIST_W){1'b0}}, span};
    end
    if (cmd.store) begin
      unique case (cmd.op)
        OP_PHASE:   t    <= (period == '0) ? '0 : rem;
        OP_CARRIER: car  <= car_next;
        OP_LEVEL_A: sw_a <= lvl_ge;
        OP_LEVEL_B: sw_b <= lvl_ge;
        OP_LEVEL_C: sw_c <= lvl_ge;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      switch_a      <= sw_a;
      switch_b      <= sw_b;
      switch_c      <= sw_c;
      carrier_value <= car;
    end
  end

endmodule
`default_nettype wire

@@ src/cpwm_ctrl.sv @@
`default_nettype none
module cpwm_ctrl
  import cpwm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DIST  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]      state, state_next;
  logic [OP_W-1:0] op, op_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.diff   = 1'b1;
        op_next    = OP_PHASE;
        state_next = S_START;
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (status.div_done) begin
          cmd.store = 1'b1;
          if (op == OP_PHASE) begin
            state_next = S_DIST;
          end else if (op == OP_NEXT) begin
            state_next = S_FIN;
          end else begin
            op_next    = op + 1'b1;
            state_next = S_START;
          end
        end
      end
      S_DIST: begin
        cmd.span   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        op_next    = OP_CARRIER;
        state_next = S_START;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_PHASE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.emit)      out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ src/cpwm_checker.sv @@
`default_nettype none
module cpwm_checker
  import cpwm_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                switch_a,
  input wire logic                switch_b,
  input wire logic                switch_c,
  input wire logic [SAMPLE_W-1:0] carrier_value
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      $stable({switch_a, switch_b, switch_c, carrier_value}))
    else $error("stalled result changed");

endmodule

bind carrier_pwm_min_max_injection cpwm_checker u_cpwm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .switch_a     (out_ch.switch_a),
  .switch_b     (out_ch.switch_b),
  .switch_c     (out_ch.switch_c),
  .carrier_value(out_ch.carrier_value)
);
`default_nettype wire
